// ----- rtl/core/bcpg_pkg.sv -----
`default_nettype none
package bcpg_pkg;

	// control point store depth
	localparam int MAX_POINTS = 16;
	localparam int PT_IDX_W   = $clog2(MAX_POINTS);
	localparam int PT_CNT_W   = $clog2(MAX_POINTS + 1);

	// segment count limits and derived widths
	localparam int SEG_W      = 7;
	localparam int SEG_MIN    = 2;
	localparam int SEG_MAX    = 64;
	localparam int SEG_RESET  = 16;
	localparam int DIVR_W     = $clog2(SEG_MAX);

	// t runs from 0 to 1.0 in Q1.16
	localparam int FRAC_W     = 16;
	localparam int T_W        = FRAC_W + 1;
	localparam logic [T_W-1:0] T_ONE = T_W'(1) << FRAC_W;

	// FIFO depth between front and back
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic        [31:0] vertex_color;
		logic               last_point;
	} point_t;

	typedef struct packed {
		logic signed [31:0] vertex_x;
		logic signed [31:0] vertex_y;
		logic        [31:0] out_color;
		logic        [15:0] vertex_index;
		logic signed [31:0] box_min_x;
		logic signed [31:0] box_min_y;
		logic signed [31:0] box_max_x;
		logic signed [31:0] box_max_y;
		logic               last_vertex;
	} vertex_t;

	// what the closing word asks for
	typedef enum logic [1:0] {
		CLS_NONE  = 2'd0,
		CLS_DROP  = 2'd1,
		CLS_PAIR  = 2'd2,
		CLS_CURVE = 2'd3
	} cls_t;

	typedef struct packed {
		logic signed [31:0]  pt_x;
		logic signed [31:0]  pt_y;
		logic        [31:0]  color;
		logic                keep;
		logic [PT_IDX_W-1:0] idx;
		cls_t                cls;
		logic [PT_CNT_W-1:0] n;
	} cmd_t;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_DIV  = 6'b000010,
		ST_LOAD = 6'b000100,
		ST_MUL  = 6'b001000,
		ST_ADD  = 6'b010000,
		ST_EMIT = 6'b100000
	} back_st_t;

endpackage
`default_nettype wire

// ----- rtl/core/bezier_curve_point_generator_top.sv -----
// Points are taken one word a cycle while the command queue has room.
// From a closing word to the first vertex the back end forms 1.0/(segment_count-1)
// in the divider, loads the store, then runs each lerp as a multiply and an add step;
// a pair is emitted directly. Each further curve vertex reloads and redoes the lerps.
// Reset clears the point count, vertex index and bounding box; segment count returns to 16.
`default_nettype none
module bezier_curve_point_generator_top (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       point_valid,
	output logic                            point_stall,
	input  wire bcpg_pkg::point_t           point,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [bcpg_pkg::SEG_W-1:0] cfg_data,
	output logic                            vertex_valid,
	input  wire logic                       vertex_stall,
	output bcpg_pkg::vertex_t               vertex
);
	import bcpg_pkg::*;

	logic q_full, push, pop, q_nonempty;
	cmd_t cmd_in, cmd_out;

	bcpg_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.point_valid (point_valid),
		.point       (point),
		.q_full      (q_full),
		.point_stall (point_stall),
		.push        (push),
		.cmd         (cmd_in)
	);

	bcpg_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wdata    (cmd_in),
		.full     (q_full),
		.pop      (pop),
		.rdata    (cmd_out),
		.nonempty (q_nonempty)
	);

	bcpg_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (q_nonempty),
		.cmd          (cmd_out),
		.cmd_pop      (pop),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.vertex_valid (vertex_valid),
		.vertex_stall (vertex_stall),
		.vertex       (vertex)
	);
endmodule
`default_nettype wire

// ----- rtl/core/bcpg_div.sv -----
`default_nettype none
module bcpg_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [bcpg_pkg::DIVR_W-1:0]  divisor,
	output logic                              done,
	output logic [bcpg_pkg::T_W-1:0]          quo,
	output logic [bcpg_pkg::DIVR_W-1:0]       rem
);
	import bcpg_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [4:0]           cnt_q;
	logic [T_W-1:0]       dvd_q;
	logic [T_W-1:0]       quo_q;
	logic [DIVR_W-1:0]    rem_q;
	logic [DIVR_W-1:0]    dsr_q;
	logic [DIVR_W:0]      rem_sh;
	logic                 fits;

	// restoring division of 1.0 by the divisor, one quotient bit a cycle
	assign rem_sh = {rem_q, dvd_q[T_W-1]};
	assign fits   = rem_sh >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(T_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= T_ONE;
			quo_q <= '0;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			quo_q <= {quo_q[T_W-2:0], fits};
			rem_q <= fits ? DIVR_W'(rem_sh - {1'b0, dsr_q}) : rem_sh[DIVR_W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;
endmodule
`default_nettype wire

// ----- rtl/core/bcpg_fifo.sv -----
`default_nettype none
module bcpg_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire bcpg_pkg::cmd_t  wdata,
	output logic                 full,
	input  wire logic            pop,
	output bcpg_pkg::cmd_t       rdata,
	output logic                 nonempty
);
	import bcpg_pkg::*;

	cmd_t                  mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_q;
	logic [FIFO_PTR_W-1:0] rd_q;
	logic [FIFO_CNT_W-1:0] cnt_q;

	assign full     = cnt_q == FIFO_CNT_W'(FIFO_DEPTH);
	assign nonempty = cnt_q != '0;
	assign rdata    = mem_q[rd_q];

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wdata;
	end
endmodule
`default_nettype wire

// ----- rtl/core/bcpg_front.sv -----
`default_nettype none
module bcpg_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             point_valid,
	input  wire bcpg_pkg::point_t point,
	input  wire logic             q_full,
	output logic                  point_stall,
	output logic                  push,
	output bcpg_pkg::cmd_t        cmd
);
	import bcpg_pkg::*;

	logic [PT_CNT_W-1:0] count_q;
	logic                keep;
	logic [PT_CNT_W-1:0] n;

	assign point_stall = q_full;
	assign push        = point_valid && !q_full;

	// classify the word: keep it if the store has room, and size the set on close
	assign keep = count_q < PT_CNT_W'(MAX_POINTS);
	assign n    = count_q + PT_CNT_W'(keep);

	always_comb begin
		cmd.pt_x  = point.point_x;
		cmd.pt_y  = point.point_y;
		cmd.color = point.vertex_color;
		cmd.keep  = keep;
		cmd.idx   = count_q[PT_IDX_W-1:0];
		cmd.n     = n;
		if (!point.last_point)                cmd.cls = CLS_NONE;
		else if (n < PT_CNT_W'(2))            cmd.cls = CLS_DROP;
		else if (n == PT_CNT_W'(2))           cmd.cls = CLS_PAIR;
		else                                  cmd.cls = CLS_CURVE;
	end

	// count loaded points, restart after the closing word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (push) begin
			count_q <= point.last_point ? '0 : n;
		end
	end
endmodule
`default_nettype wire

// ----- rtl/core/bcpg_back.sv -----
`default_nettype none
module bcpg_back (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cmd_valid,
	input  wire bcpg_pkg::cmd_t             cmd,
	output logic                            cmd_pop,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [bcpg_pkg::SEG_W-1:0] cfg_data,
	output logic                            vertex_valid,
	input  wire logic                       vertex_stall,
	output bcpg_pkg::vertex_t               vertex
);
	import bcpg_pkg::*;

	back_st_t                state_q;
	logic [SEG_W-1:0]        seg_q;
	logic signed [31:0]      store_x_q [MAX_POINTS];
	logic signed [31:0]      store_y_q [MAX_POINTS];
	logic signed [31:0]      w_x_q [MAX_POINTS];
	logic signed [31:0]      w_y_q [MAX_POINTS];
	logic                    pair_q;
	logic [31:0]             color_q;
	logic [DIVR_W-1:0]       d_q;
	logic [T_W-1:0]          q0_q;
	logic [DIVR_W-1:0]       r0_q;
	logic [T_W-1:0]          t_q;
	logic [DIVR_W-1:0]       rem_q;
	logic [DIVR_W-1:0]       k_q;
	logic [PT_IDX_W-1:0]     i_q;
	logic [PT_IDX_W-1:0]     r_q;
	logic [PT_CNT_W-1:0]     n_q;
	logic signed [50:0]      prod_x_s1;
	logic signed [50:0]      prod_y_s1;
	logic [15:0]             vcnt_q;
	logic signed [31:0]      lo_x_q, lo_y_q, hi_x_q, hi_y_q;
	logic                    out_valid_q;
	vertex_t                 out_q;

	logic [SEG_W-1:0]        seg_c;
	logic                    div_start;
	logic                    div_done;
	logic [T_W-1:0]          div_quo;
	logic [DIVR_W-1:0]       div_rem;
	logic                    out_free;
	logic                    emit_fire;
	logic signed [31:0]      vx, vy;
	logic signed [31:0]      nlo_x, nlo_y, nhi_x, nhi_y;
	logic                    vlast;
	logic [PT_IDX_W-1:0]     i_nx;
	logic signed [32:0]      dx, dy;
	logic signed [50:0]      shx, shy;
	logic [DIVR_W:0]         rem_sum;

	assign cfg_ready = 1'b1;

	// clamp the segment count to its working range
	always_comb begin
		if (seg_q < SEG_W'(SEG_MIN))      seg_c = SEG_W'(SEG_MIN);
		else if (seg_q > SEG_W'(SEG_MAX)) seg_c = SEG_W'(SEG_MAX);
		else                              seg_c = seg_q;
	end

	assign cmd_pop   = (state_q == ST_IDLE) && cmd_valid;
	assign div_start = cmd_pop && (cmd.cls == CLS_CURVE);

	bcpg_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.divisor (DIVR_W'(seg_c - SEG_W'(1))),
		.done    (div_done),
		.quo     (div_quo),
		.rem     (div_rem)
	);

	// vertex under emission and the box it grows
	assign out_free  = !out_valid_q || !vertex_stall;
	assign emit_fire = (state_q == ST_EMIT) && out_free;
	assign vx       = pair_q ? store_x_q[PT_IDX_W'(k_q[0])] : w_x_q[0];
	assign vy       = pair_q ? store_y_q[PT_IDX_W'(k_q[0])] : w_y_q[0];
	assign vlast    = pair_q ? (k_q[0] == 1'b1) : (k_q == d_q);
	assign nlo_x    = (vx < lo_x_q) ? vx : lo_x_q;
	assign nlo_y    = (vy < lo_y_q) ? vy : lo_y_q;
	assign nhi_x    = (vx > hi_x_q) ? vx : hi_x_q;
	assign nhi_y    = (vy > hi_y_q) ? vy : hi_y_q;

	// lerp datapath: difference times t, then floor shift and add
	assign i_nx    = i_q + 1'b1;
	assign dx      = 33'(w_x_q[i_nx]) - 33'(w_x_q[i_q]);
	assign dy      = 33'(w_y_q[i_nx]) - 33'(w_y_q[i_q]);
	assign shx     = prod_x_s1 >>> FRAC_W;
	assign shy     = prod_y_s1 >>> FRAC_W;
	assign rem_sum = {1'b0, rem_q} + {1'b0, r0_q};

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seg_q       <= SEG_W'(SEG_RESET);
			vcnt_q      <= '0;
			lo_x_q      <= 32'sh7FFFFFFF;
			lo_y_q      <= 32'sh7FFFFFFF;
			hi_x_q      <= 32'sh80000000;
			hi_y_q      <= 32'sh80000000;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) seg_q <= cfg_data;
			// hold the output word until taken, refill it on emission
			if (emit_fire)          out_valid_q <= 1'b1;
			else if (!vertex_stall) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (cmd_pop) begin
						case (cmd.cls)
							CLS_PAIR:  state_q <= ST_EMIT;
							CLS_CURVE: state_q <= ST_DIV;
							default:   state_q <= ST_IDLE;
						endcase
					end
				end
				ST_DIV: begin
					if (div_done) state_q <= ST_LOAD;
				end
				ST_LOAD: state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_ADD;
				ST_ADD: begin
					if (i_nx != r_q || r_q != PT_IDX_W'(1)) state_q <= ST_MUL;
					else                                    state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						vcnt_q      <= vcnt_q + 16'd1;
						lo_x_q      <= nlo_x;
						lo_y_q      <= nlo_y;
						hi_x_q      <= nhi_x;
						hi_y_q      <= nhi_y;
						if (vlast)       state_q <= ST_IDLE;
						else if (pair_q) state_q <= ST_EMIT;
						else             state_q <= ST_LOAD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (cmd_pop) begin
					if (cmd.keep) begin
						store_x_q[cmd.idx] <= cmd.pt_x;
						store_y_q[cmd.idx] <= cmd.pt_y;
					end
					pair_q  <= cmd.cls == CLS_PAIR;
					color_q <= cmd.color;
					n_q     <= cmd.n;
					d_q     <= DIVR_W'(seg_c - SEG_W'(1));
					k_q     <= '0;
				end
			end
			ST_DIV: begin
				q0_q  <= div_quo;
				r0_q  <= div_rem;
				t_q   <= '0;
				rem_q <= '0;
			end
			ST_LOAD: begin
				for (int j = 0; j < MAX_POINTS; j++) begin
					w_x_q[j] <= store_x_q[j];
					w_y_q[j] <= store_y_q[j];
				end
				r_q <= PT_IDX_W'(n_q - PT_CNT_W'(1));
				i_q <= '0;
			end
			ST_MUL: begin
				prod_x_s1 <= dx * $signed({1'b0, t_q});
				prod_y_s1 <= dy * $signed({1'b0, t_q});
			end
			ST_ADD: begin
				w_x_q[i_q] <= w_x_q[i_q] + shx[31:0];
				w_y_q[i_q] <= w_y_q[i_q] + shy[31:0];
				if (i_nx != r_q) begin
					i_q <= i_nx;
				end else begin
					i_q <= '0;
					r_q <= r_q - 1'b1;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					out_q.vertex_x     <= vx;
					out_q.vertex_y     <= vy;
					out_q.out_color    <= color_q;
					out_q.vertex_index <= vcnt_q;
					out_q.box_min_x    <= nlo_x;
					out_q.box_min_y    <= nlo_y;
					out_q.box_max_x    <= nhi_x;
					out_q.box_max_y    <= nhi_y;
					out_q.last_vertex  <= vlast;
					k_q                <= k_q + 1'b1;
					// step t by 1.0/d, carrying the remainder
					if (rem_sum >= {1'b0, d_q}) begin
						rem_q <= DIVR_W'(rem_sum - {1'b0, d_q});
						t_q   <= t_q + q0_q + T_W'(1);
					end else begin
						rem_q <= rem_sum[DIVR_W-1:0];
						t_q   <= t_q + q0_q;
					end
				end
			end
			default: ;
		endcase
	end

	assign vertex_valid = out_valid_q;
	assign vertex       = out_q;
endmodule
`default_nettype wire

// ----- rtl/core/bcpg_checker.sv -----
`default_nettype none
module bcpg_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              vertex_valid,
	input wire logic              vertex_stall,
	input wire bcpg_pkg::vertex_t vertex
);
	import bcpg_pkg::*;

	logic        seen_q;
	logic [15:0] exp_q;

	// track the next expected vertex index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
			exp_q  <= '0;
		end else if (vertex_valid && !vertex_stall) begin
			seen_q <= 1'b1;
			exp_q  <= vertex.vertex_index + 16'd1;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vertex_valid && vertex_stall |=> vertex_valid && $stable(vertex))
		else $error("stalled vertex word changed");

	a_box_x: assert property (@(posedge clk) disable iff (!arst_n)
		vertex_valid |-> vertex.box_min_x <= vertex.vertex_x &&
			vertex.vertex_x <= vertex.box_max_x)
		else $error("vertex x outside bounding box");

	a_box_y: assert property (@(posedge clk) disable iff (!arst_n)
		vertex_valid |-> vertex.box_min_y <= vertex.vertex_y &&
			vertex.vertex_y <= vertex.box_max_y)
		else $error("vertex y outside bounding box");

	a_index: assert property (@(posedge clk) disable iff (!arst_n)
		vertex_valid && seen_q |-> vertex.vertex_index == exp_q)
		else $error("vertex index skipped or repeated");
endmodule

bind bezier_curve_point_generator_top bcpg_checker u_bcpg_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.vertex_valid (vertex_valid),
	.vertex_stall (vertex_stall),
	.vertex       (vertex)
);
`default_nettype wire

// ----- bench/bcpg_vertex_checker.sv -----
module bcpg_vertex_checker (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       point_valid,
	input  wire logic                       point_stall,
	input  wire bcpg_pkg::point_t           point,
	input  wire logic                       cfg_valid,
	input  wire logic                       cfg_ready,
	input  wire logic [bcpg_pkg::SEG_W-1:0] cfg_data,
	input  wire logic                       vertex_valid,
	input  wire logic                       vertex_stall,
	input  wire bcpg_pkg::vertex_t          vertex,
	output int                              errors,
	output int                              pending,
	output int                              vertices_seen,
	output int                              curves_seen
);
	import bcpg_pkg::*;

	// shadow of the block state
	longint           ctrl_x [MAX_POINTS];
	longint           ctrl_y [MAX_POINTS];
	int               n_loaded;
	logic [15:0]      vert_num;
	logic signed [31:0] bb_lo_x, bb_lo_y, bb_hi_x, bb_hi_y;
	logic [SEG_W-1:0] seg_setting;
	vertex_t          vertex_queue[$];

	assign pending = vertex_queue.size();

	// add one vertex to the box and queue what the block should send
	function automatic void queue_vertex(longint x, longint y, logic [31:0] colour,
			logic is_last);
		vertex_t v;
		logic signed [31:0] sx, sy;
		sx = x[31:0];
		sy = y[31:0];
		if (sx < bb_lo_x) bb_lo_x = sx;
		if (sy < bb_lo_y) bb_lo_y = sy;
		if (sx > bb_hi_x) bb_hi_x = sx;
		if (sy > bb_hi_y) bb_hi_y = sy;
		v.vertex_x     = sx;
		v.vertex_y     = sy;
		v.out_color    = colour;
		v.vertex_index = vert_num;
		v.box_min_x    = bb_lo_x;
		v.box_min_y    = bb_lo_y;
		v.box_max_x    = bb_hi_x;
		v.box_max_y    = bb_hi_y;
		v.last_vertex  = is_last;
		vertex_queue.insert(vertex_queue.size(), v);
		vert_num = vert_num + 16'd1;
	endfunction

	// load a point; on the closing word evaluate the curve by de Casteljau
	function automatic void load_point(point_t p);
		longint wx [MAX_POINTS];
		longint wy [MAX_POINTS];
		int n, seg, t;
		if (n_loaded < MAX_POINTS) begin
			ctrl_x[n_loaded] = longint'(p.point_x);
			ctrl_y[n_loaded] = longint'(p.point_y);
			n_loaded++;
		end
		if (!p.last_point)
			return;
		n = n_loaded;
		n_loaded = 0;
		if (n < 2)
			return;
		curves_seen++;
		if (n == 2) begin
			queue_vertex(ctrl_x[0], ctrl_y[0], p.vertex_color, 1'b0);
			queue_vertex(ctrl_x[1], ctrl_y[1], p.vertex_color, 1'b1);
			return;
		end
		seg = seg_setting;
		if (seg < SEG_MIN) seg = SEG_MIN;
		if (seg > SEG_MAX) seg = SEG_MAX;
		for (int k = 0; k < seg; k++) begin
			t = (k * 65536) / (seg - 1);
			for (int i = 0; i < n; i++) begin
				wx[i] = ctrl_x[i];
				wy[i] = ctrl_y[i];
			end
			for (int r = n - 1; r > 0; r--)
				for (int i = 0; i < r; i++) begin
					wx[i] = wx[i] + (((wx[i+1] - wx[i]) * t) >>> 16);
					wy[i] = wy[i] + (((wy[i+1] - wy[i]) * t) >>> 16);
				end
			queue_vertex(wx[0], wy[0], p.vertex_color, k == seg - 1);
		end
	endfunction

	// watch all three channels at the clock edge
	always @(posedge clk or negedge arst_n) begin
		vertex_t want;
		if (!arst_n) begin
			n_loaded      = 0;
			vert_num      = '0;
			bb_lo_x       = 32'sh7FFFFFFF;
			bb_lo_y       = 32'sh7FFFFFFF;
			bb_hi_x       = 32'sh80000000;
			bb_hi_y       = 32'sh80000000;
			seg_setting   = SEG_W'(SEG_RESET);
			errors        = 0;
			vertices_seen = 0;
			curves_seen   = 0;
			vertex_queue.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				seg_setting = cfg_data;
			if (point_valid && !point_stall)
				load_point(point);
			if (vertex_valid && !vertex_stall) begin
				vertices_seen++;
				if (vertex_queue.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("ERROR: unexpected vertex word %p", vertex);
				end else begin
					want = vertex_queue.pop_front();
					if (vertex.vertex_x !== want.vertex_x
							|| vertex.vertex_y !== want.vertex_y
							|| vertex.out_color !== want.out_color
							|| vertex.vertex_index !== want.vertex_index
							|| vertex.box_min_x !== want.box_min_x
							|| vertex.box_min_y !== want.box_min_y
							|| vertex.box_max_x !== want.box_max_x
							|| vertex.box_max_y !== want.box_max_y
							|| vertex.last_vertex !== want.last_vertex) begin
						errors++;
						if (errors <= 10)
							$display("ERROR: vertex mismatch\n  expected %p\n  actual   %p",
								want, vertex);
					end
				end
			end
		end
	end

endmodule

// ----- bench/tb_bezier_curve_point_generator_top.sv -----
module tb_bezier_curve_point_generator_top;
	import bcpg_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int IDLE_GUARD  = 600;
	localparam int LONG_HOLD   = 400;

	logic             clk;
	logic             arst_n;
	logic             point_valid;
	logic             point_stall;
	point_t           point;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [SEG_W-1:0] cfg_data;
	logic             vertex_valid;
	logic             vertex_stall;
	vertex_t          vertex;

	int errors, pending, vertices_seen, curves_seen;
	int points_sent;
	int cycles;
	bit quiet;
	int hold_asked, hold_done;

	bezier_curve_point_generator_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.point_valid  (point_valid),
		.point_stall  (point_stall),
		.point        (point),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.vertex_valid (vertex_valid),
		.vertex_stall (vertex_stall),
		.vertex       (vertex)
	);

	bcpg_vertex_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.point_valid   (point_valid),
		.point_stall   (point_stall),
		.point         (point),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.vertex_valid  (vertex_valid),
		.vertex_stall  (vertex_stall),
		.vertex        (vertex),
		.errors        (errors),
		.pending       (pending),
		.vertices_seen (vertices_seen),
		.curves_seen   (curves_seen)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// bound the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// receiver: random stall bursts, one long hold on request
	initial begin
		vertex_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_asked > hold_done) begin
				hold_done++;
				vertex_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 2) == 0) begin
				vertex_stall <= 1'b1;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end else begin
				vertex_stall <= 1'b0;
				repeat ($urandom_range(1, quiet ? 1 : 20)) @(posedge clk);
			end
		end
	end

	// offer one point word, with an occasional gap ahead of it
	task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] colour,
			logic closing);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			point_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		point_valid        <= 1'b1;
		point.point_x      <= x;
		point.point_y      <= y;
		point.vertex_color <= colour;
		point.last_point   <= closing;
		do @(posedge clk); while (point_stall);
		points_sent++;
	endtask

	// let the checker see the last accepted word, then wait for every vertex
	task automatic drain();
		point_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (IDLE_GUARD) @(posedge clk);
	endtask

	// write segment_count once the block has gone idle
	task automatic write_segments(logic [SEG_W-1:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
			2: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
			default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
		endcase
	endfunction

	// one point set closed on its final word
	task automatic send_set(int n);
		for (int i = 0; i < n; i++)
			send_point(rand_coord(), rand_coord(), $urandom, i == n - 1);
	endtask

	task automatic random_sets(int count);
		int roll;
		for (int s = 0; s < count; s++) begin
			roll = $urandom_range(0, 99);
			if (roll < 65) send_set($urandom_range(2, 5));
			else if (roll < 75) send_set($urandom_range(6, 10));
			else if (roll < 80) send_set($urandom_range(11, 19));
			else if (roll < 87) send_set(1);
			else if (roll < 93) send_set(3);
			else begin
				// stray words left open, then closed by the next set
				for (int i = 0; i < $urandom_range(1, 3); i++)
					send_point(rand_coord(), rand_coord(), $urandom, 1'b0);
				send_set($urandom_range(1, 3));
			end
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		cycles      = 0;
		quiet       = 1'b0;
		hold_asked  = 0;
		hold_done   = 0;
		points_sent = 0;
		point_valid = 1'b0;
		point       = '0;
		cfg_valid   = 1'b0;
		cfg_data    = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, pair, too few, curve, full store, overflow close
		send_point(32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 1'b0);
		send_point(32'h80000000, 32'h7FFFFFFF, 32'h00000000, 1'b1);
		send_point(32'h12345678, 32'h9ABCDEF0, 32'hA5A5A5A5, 1'b1);
		send_point(32'h80000000, 32'h80000000, 32'h5A5A5A5A, 1'b0);
		send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h5A5A5A5A, 1'b0);
		send_point(32'h00000000, 32'hFFFFFFFF, 32'h0F0F0F0F, 1'b1);
		send_set(16);
		send_set(18);
		drain();

		// walk segment_count through its corners, the clamped ones too
		write_segments(7'd0);
		send_set(3);
		send_set(2);
		write_segments(7'd1);
		send_set(4);
		write_segments(7'd2);
		random_sets(6);
		write_segments(7'd64);
		send_set(4);
		send_set(16);
		write_segments(7'd127);
		send_set(3);
		write_segments(7'd65);
		send_set(3);

		// receiver holds off while points keep coming
		write_segments(7'd8);
		hold_asked++;
		random_sets(8);
		// sender waits for every vertex before going on
		point_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		random_sets(10);

		while (points_sent < 210) begin
			write_segments(7'($urandom_range(2, 24)));
			random_sets(6);
		end
		write_segments(7'd16);
		quiet = 1'b1;
		random_sets(12);
		drain();

		$display("Sent %0d point words over %0d curves, checked %0d vertex words.",
			points_sent, curves_seen, vertices_seen);
		$display("Segment counts 0..127 incl. clamped values, store overflow and long holds.");
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
